FILE: rtl/tht_pkg.sv
// Shared types and constants for the typed handle table.
// Request and response beat layouts, operation and status codes, and the
// command and status groups between the controller and the datapath.
`default_nettype none

package tht_pkg;

    // Operation selectors
    localparam logic [1:0] FUNC_ADD     = 2'd0;
    localparam logic [1:0] FUNC_GET     = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_LIVE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Kind tag of a free slot
    localparam logic [2:0] KIND_FREE = 3'd0;

    // Free bitmap row geometry
    localparam int FREE_ROW_LOG  = 4;
    localparam int FREE_ROW_BITS = 1 << FREE_ROW_LOG;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  kind;
        logic [47:0] payload;
        logic [15:0] handle_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_handle;
        logic [47:0] found_payload;
    } t_rsp;

    // Datapath action for the current cycle
    typedef enum logic [2:0] {
        ACT_IDLE,
        ACT_CAPTURE,
        ACT_ISSUE,
        ACT_CHECK,
        ACT_RELEASE,
        ACT_EXTEND,
        ACT_SCAN,
        ACT_FINISH
    } t_act;

    // Route an accepted request takes after decode
    typedef enum logic [2:0] {
        PATH_RESULT,
        PATH_GET,
        PATH_RELEASE,
        PATH_EXTEND,
        PATH_SCAN
    } t_path;

    typedef struct packed {
        t_act act;
    } t_cmd;

    typedef struct packed {
        t_path path;
        logic  scan_hit;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/tht_ctrl.sv
// Controller state machine of the typed handle table.
// Sequences one request at a time through the datapath; uses tht_pkg.
`default_nettype none

module tht_ctrl
    import tht_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_CHECK,
        S_RELEASE,
        S_EXTEND,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_busy;

    // State and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_ISSUE;
                        r_busy  <= 1'b1;
                    end
                end
                S_ISSUE: begin
                    unique case (i_sts.path)
                        PATH_GET:     r_state <= S_CHECK;
                        PATH_RELEASE: r_state <= S_RELEASE;
                        PATH_EXTEND:  r_state <= S_EXTEND;
                        PATH_SCAN:    r_state <= S_SCAN;
                        default:      r_state <= S_FINISH;
                    endcase
                end
                S_CHECK, S_RELEASE, S_EXTEND: begin
                    r_state <= S_FINISH;
                end
                S_SCAN: begin
                    if (i_sts.scan_hit) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // Action decode
    always_comb begin
        unique case (r_state)
            S_IDLE:    o_cmd.act = i_in_valid ? ACT_CAPTURE : ACT_IDLE;
            S_ISSUE:   o_cmd.act = ACT_ISSUE;
            S_CHECK:   o_cmd.act = ACT_CHECK;
            S_RELEASE: o_cmd.act = ACT_RELEASE;
            S_EXTEND:  o_cmd.act = ACT_EXTEND;
            S_SCAN:    o_cmd.act = ACT_SCAN;
            S_FINISH:  o_cmd.act = ACT_FINISH;
            default:   o_cmd.act = ACT_IDLE;
        endcase
    end

    assign o_in_stall = r_busy;

endmodule

`default_nettype wire

FILE: rtl/tht_dpath.sv
// Datapath of the typed handle table: slot memory, free bitmap memory,
// high-water mark, free count, lowest-free hint and output register; uses tht_pkg.
`default_nettype none

module tht_dpath
    import tht_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int PAYLOAD_BITS = 48
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_req i_in_data,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_rsp o_out_data
);

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int MW     = $clog2(TABLE_DEPTH + 1);
    localparam int ROWS   = (TABLE_DEPTH + FREE_ROW_BITS - 1) / FREE_ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW     = 3 + PAYLOAD_BITS;

    // Memories
    logic [SW-1:0]            slot_mem [TABLE_DEPTH];
    logic [FREE_ROW_BITS-1:0] free_mem [ROWS];

    // Payload registers
    t_req                     r_req;
    logic [SW-1:0]            r_slot_q;
    logic [FREE_ROW_BITS-1:0] r_row_q;
    logic [ROW_AW-1:0]        r_rd_row;
    logic [ROW_AW-1:0]        r_scan_row;
    t_rsp                     r_res;
    t_rsp                     r_out;

    // Control registers
    logic [MW-1:0] r_mark;
    logic [MW-1:0] r_free_cnt;
    logic [MW-1:0] r_hint;
    logic          r_out_valid;

    logic [MW-1:0] n_mark;
    logic [MW-1:0] n_free_cnt;
    logic [MW-1:0] n_hint;

    // Decode and addressing
    logic [IW-1:0]            idx_h;
    logic                     in_range;
    logic                     out_free;
    logic [PAYLOAD_BITS-1:0]  pay_st;
    logic                     kind_free;
    t_path                    path;
    logic [1:0]               res_status;
    logic                     scan_hit;
    logic [FREE_ROW_LOG-1:0]  hit_pos;
    logic [IW-1:0]            found_idx;
    logic [2:0]               q_kind;
    logic [PAYLOAD_BITS-1:0]  q_pay;

    logic                     slot_we;
    logic                     slot_re;
    logic [IW-1:0]            slot_wa;
    logic [SW-1:0]            slot_wd;
    logic                     row_we;
    logic                     row_re;
    logic [ROW_AW-1:0]        row_ra;
    logic [FREE_ROW_LOG-1:0]  bit_pos;
    logic                     bit_val;
    logic [FREE_ROW_BITS-1:0] row_wd;

    assign idx_h     = IW'(r_req.handle_id - 16'd1);
    assign in_range  = (r_req.handle_id != 16'd0) && (17'(r_req.handle_id) <= 17'(r_mark));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pay_st    = PAYLOAD_BITS'(r_req.payload);
    assign kind_free = (r_req.kind == KIND_FREE);
    assign q_kind    = r_slot_q[SW-1 -: 3];
    assign q_pay     = r_slot_q[PAYLOAD_BITS-1:0];

    // Route of the held request
    always_comb begin
        path       = PATH_RESULT;
        res_status = ST_OK;
        unique case (r_req.func)
            FUNC_ADD: begin
                if (r_free_cnt != '0) begin
                    path = PATH_SCAN;
                end else if (r_mark == MW'(TABLE_DEPTH)) begin
                    res_status = ST_FULL;
                end else begin
                    path = PATH_EXTEND;
                end
            end
            FUNC_GET: begin
                if (in_range) begin
                    path = PATH_GET;
                end else begin
                    res_status = ST_NOT_LIVE;
                end
            end
            FUNC_RELEASE: begin
                if (in_range) begin
                    path = PATH_RELEASE;
                end
            end
            default: begin
                path = PATH_RESULT;
            end
        endcase
    end

    // Lowest free bit of the bitmap row just read
    always_comb begin
        scan_hit = 1'b0;
        hit_pos  = '0;
        for (int j = 0; j < FREE_ROW_BITS; j++) begin
            if (!scan_hit && r_row_q[j]) begin
                scan_hit = 1'b1;
                hit_pos  = FREE_ROW_LOG'(j);
            end
        end
    end

    assign found_idx = IW'({r_rd_row, hit_pos});

    // Memory port control
    always_comb begin
        slot_we = 1'b0;
        slot_re = 1'b0;
        slot_wa = idx_h;
        slot_wd = {r_req.kind, pay_st};
        row_we  = 1'b0;
        row_re  = 1'b0;
        row_ra  = r_scan_row;
        bit_pos = 4'(idx_h);
        bit_val = kind_free;
        unique case (i_cmd.act)
            ACT_ISSUE: begin
                unique case (path)
                    PATH_GET: begin
                        slot_re = 1'b1;
                    end
                    PATH_RELEASE: begin
                        slot_re = 1'b1;
                        row_re  = 1'b1;
                        row_ra  = ROW_AW'(idx_h >> FREE_ROW_LOG);
                    end
                    PATH_EXTEND: begin
                        slot_we = 1'b1;
                        slot_wa = IW'(r_mark);
                        row_re  = 1'b1;
                        row_ra  = ROW_AW'(r_mark >> FREE_ROW_LOG);
                    end
                    PATH_SCAN: begin
                        row_re = 1'b1;
                        row_ra = ROW_AW'(r_hint >> FREE_ROW_LOG);
                    end
                    default: begin
                        row_re = 1'b0;
                    end
                endcase
            end
            ACT_RELEASE: begin
                slot_we = 1'b1;
                slot_wd = {KIND_FREE, {PAYLOAD_BITS{1'b0}}};
                row_we  = 1'b1;
                bit_val = 1'b1;
            end
            ACT_EXTEND: begin
                row_we  = 1'b1;
                bit_pos = 4'(r_mark);
            end
            ACT_SCAN: begin
                if (scan_hit) begin
                    slot_we = 1'b1;
                    slot_wa = found_idx;
                    row_we  = 1'b1;
                    bit_pos = hit_pos;
                end else begin
                    row_re = 1'b1;
                end
            end
            default: begin
                slot_we = 1'b0;
            end
        endcase
    end

    // Read-modify-write of one bitmap bit
    always_comb begin
        row_wd          = r_row_q;
        row_wd[bit_pos] = bit_val;
    end

    // Table state updates
    always_comb begin
        n_mark     = r_mark;
        n_free_cnt = r_free_cnt;
        n_hint     = r_hint;
        unique case (i_cmd.act)
            ACT_RELEASE: begin
                if (q_kind != KIND_FREE) begin
                    n_free_cnt = r_free_cnt + 1'b1;
                end
                if (MW'(idx_h) < r_hint) begin
                    n_hint = MW'(idx_h);
                end
            end
            ACT_EXTEND: begin
                n_mark = r_mark + 1'b1;
                if (kind_free) begin
                    n_free_cnt = r_free_cnt + 1'b1;
                end
            end
            ACT_SCAN: begin
                if (scan_hit) begin
                    if (kind_free) begin
                        n_hint = MW'(found_idx);
                    end else begin
                        n_free_cnt = r_free_cnt - 1'b1;
                        n_hint     = MW'(found_idx) + 1'b1;
                    end
                end
            end
            default: begin
                n_mark = r_mark;
            end
        endcase
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re) begin
            r_slot_q <= slot_mem[idx_h];
        end
        if (row_we) begin
            free_mem[r_rd_row] <= row_wd;
        end
        if (row_re) begin
            r_row_q  <= free_mem[row_ra];
            r_rd_row <= row_ra;
        end
    end

    // Request, scan cursor and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.act == ACT_CAPTURE) begin
            r_req <= i_in_data;
        end
        if (i_cmd.act == ACT_ISSUE) begin
            r_scan_row <= ROW_AW'(r_hint >> FREE_ROW_LOG) + 1'b1;
        end else if (i_cmd.act == ACT_SCAN && !scan_hit) begin
            r_scan_row <= r_scan_row + 1'b1;
        end
        unique case (i_cmd.act)
            ACT_ISSUE: begin
                r_res <= '{status: res_status, new_handle: 16'd0, found_payload: 48'd0};
            end
            ACT_CHECK: begin
                if (q_kind == r_req.kind && q_pay != '0) begin
                    r_res <= '{status: ST_OK, new_handle: 16'd0,
                               found_payload: 48'(q_pay)};
                end else begin
                    r_res <= '{status: ST_NOT_LIVE, new_handle: 16'd0,
                               found_payload: 48'd0};
                end
            end
            ACT_RELEASE: begin
                r_res <= '{status: ST_OK, new_handle: 16'd0, found_payload: 48'd0};
            end
            ACT_EXTEND: begin
                r_res <= '{status: ST_OK, new_handle: 16'(32'(r_mark) + 32'd1),
                           found_payload: 48'd0};
            end
            ACT_SCAN: begin
                if (scan_hit) begin
                    r_res <= '{status: ST_OK, new_handle: 16'(32'(found_idx) + 32'd1),
                               found_payload: 48'd0};
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
        if (i_cmd.act == ACT_FINISH && out_free) begin
            r_out <= r_res;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark      <= '0;
            r_free_cnt  <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mark     <= n_mark;
            r_free_cnt <= n_free_cnt;
            r_hint     <= n_hint;
            if (i_cmd.act == ACT_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.path     = path;
    assign o_sts.scan_hit = scan_hit;
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

`default_nettype wire

FILE: rtl/typed_handle_table.sv
// Typed handle table, one request in flight at a time.
// Each request is captured, issued and finished; an immediate answer (full, out
// of range, unused selector) goes straight to finish, get, release and add past
// the mark pass a check, release or extend state, and add into a freed slot scans
// 16-slot bitmap rows to a free bit. Input stall drops as the response loads.
// Reset clears the mark, free count and hint; slot memories need no clearing.
`default_nettype none

module typed_handle_table
    import tht_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int PAYLOAD_BITS = 48
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_rsp o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    tht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage and result path
    tht_dpath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/tht_checker.sv
// Port-level checks for the typed handle table, bound to the top level.
// Uses tht_pkg for beat types and status codes.
`default_nettype none

module tht_checker
    import tht_pkg::*;
(
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  i_in_valid,
    input wire  o_in_stall,
    input wire  o_out_valid,
    input wire  i_out_stall,
    input t_rsp o_out_data
);

    // One request at a time: an accepted beat stalls the input next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // A stalled response beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled response beat changed");

    // A response appears only as a request completes
    a_rsp_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(o_in_stall) && !o_in_stall))
        else $error("response beat without request in flight");

    // Reset leaves both channels quiet and ready
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("channels active after reset");

endmodule

bind typed_handle_table tht_checker u_tht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
